// ----- sv/m3pow_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// m3pow_pkg
// Shared types and constants for the 3x3 matrix power unit: request and
// response payloads, sequencer states and matrix storage geometry.
// ----------------------------------------------------------------------------
package m3pow_pkg;

    localparam int ELEM_W       = 64;
    localparam int HALF_W       = ELEM_W / 2;
    localparam int POW_W        = 32;
    localparam int MAT_DIM      = 3;
    localparam int MAT_ELEMS    = MAT_DIM * MAT_DIM;
    localparam int NUM_BANKS    = 3;
    localparam int RAM_DEPTH    = NUM_BANKS * MAT_ELEMS;
    localparam int RAM_AW       = $clog2(RAM_DEPTH);
    localparam int BANK_W       = 2;
    localparam int IDX_W        = 2;
    localparam int ELEM_IDX_W   = $clog2(MAT_ELEMS + 1);
    localparam int EXP_BITS_DEF = 32;

    // bank that receives the base matrix on load
    localparam logic [BANK_W-1:0] BANK_LOAD = '0;

    typedef struct packed {
        logic signed [ELEM_W-1:0] base_r0c0;
        logic signed [ELEM_W-1:0] base_r0c1;
        logic signed [ELEM_W-1:0] base_r0c2;
        logic signed [ELEM_W-1:0] base_r1c0;
        logic signed [ELEM_W-1:0] base_r1c1;
        logic signed [ELEM_W-1:0] base_r1c2;
        logic signed [ELEM_W-1:0] base_r2c0;
        logic signed [ELEM_W-1:0] base_r2c1;
        logic signed [ELEM_W-1:0] base_r2c2;
        logic        [POW_W-1:0]  power;
    } t_req;

    typedef struct packed {
        logic signed [ELEM_W-1:0] out_r0c0;
        logic signed [ELEM_W-1:0] out_r0c1;
        logic signed [ELEM_W-1:0] out_r0c2;
        logic signed [ELEM_W-1:0] out_r1c0;
        logic signed [ELEM_W-1:0] out_r1c1;
        logic signed [ELEM_W-1:0] out_r1c2;
        logic signed [ELEM_W-1:0] out_r2c0;
        logic signed [ELEM_W-1:0] out_r2c1;
        logic signed [ELEM_W-1:0] out_r2c2;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_BIT,
        S_RD,
        S_M0,
        S_M1,
        S_M2,
        S_ACC,
        S_OUTW,
        S_OUT
    } t_state;

    typedef enum logic {
        OP_MUL,
        OP_SQR
    } t_op;

endpackage
`default_nettype wire

// ----- sv/m3pow_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// m3pow_ram
// Generic RAM: one write port, two read ports with enable and registered
// read data.
// ----------------------------------------------------------------------------
module m3pow_ram #(
    parameter int WIDTH = m3pow_pkg::ELEM_W,
    parameter int DEPTH = m3pow_pkg::RAM_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic                     i_re_b,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

// ----- sv/matrix3_power_by_squaring_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_power_by_squaring_unit
// Raises a 3x3 matrix of 64-bit integers to an unsigned power by binary
// exponentiation, all arithmetic wrapping modulo 2^64.
// ----------------------------------------------------------------------------
// One request is worked on at a time; o_stall stays high from acceptance
// until the result has been written to the output register. All matrix
// products run through a single 32x32 multiplier and a 64-bit accumulator:
// each 64-bit element product takes three multiplier passes. A request
// first loads the base, then for every exponent bit up to the highest set
// one takes a decision, a squaring (skipped after the highest set bit) and
// a multiply for a set bit (free for the lowest set bit), and finally reads
// the result out. The three matrix banks live in one 27-entry RAM with two
// read ports; bank roles rotate so no product writes over one of its own
// operands.
// ----------------------------------------------------------------------------
module matrix3_power_by_squaring_unit #(
    parameter int EXP_BITS = m3pow_pkg::EXP_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire m3pow_pkg::t_req   i_req,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output m3pow_pkg::t_rsp        o_res
);

    localparam int EW     = (EXP_BITS < m3pow_pkg::POW_W) ? EXP_BITS : m3pow_pkg::POW_W;
    localparam int CNT_W  = m3pow_pkg::ELEM_IDX_W;
    localparam int AW     = m3pow_pkg::RAM_AW;
    localparam int EL_W   = m3pow_pkg::ELEM_W;
    localparam int HW     = m3pow_pkg::HALF_W;
    localparam int BW     = m3pow_pkg::BANK_W;
    localparam int IW     = m3pow_pkg::IDX_W;

    localparam logic [CNT_W-1:0] LAST_ELEM = CNT_W'(m3pow_pkg::MAT_ELEMS - 1);
    localparam logic [CNT_W-1:0] OUT_END   = CNT_W'(m3pow_pkg::MAT_ELEMS);
    localparam logic [IW-1:0]    LAST_IDX  = IW'(m3pow_pkg::MAT_DIM - 1);

    m3pow_pkg::t_state r_state, n_state;
    m3pow_pkg::t_op    r_op;

    logic [m3pow_pkg::MAT_ELEMS-1:0][EL_W-1:0] r_in;
    logic [m3pow_pkg::MAT_ELEMS-1:0][EL_W-1:0] r_res;
    logic [EW-1:0]    r_exp;
    logic             r_bit_mul;
    logic             r_acc_id;
    logic [BW-1:0]    r_acc_ptr;
    logic [BW-1:0]    r_sq_ptr;
    logic [BW-1:0]    r_dst;
    logic [IW-1:0]    r_row;
    logic [IW-1:0]    r_col;
    logic [IW-1:0]    r_k;
    logic [CNT_W-1:0] r_cnt;
    logic [EL_W-1:0]  r_prod;
    logic [EL_W-1:0]  r_sum;
    logic             r_ovalid;

    logic [IW-1:0]    rd_k;
    logic [BW-1:0]    bank_a;
    logic [HW-1:0]    mul_x;
    logic [HW-1:0]    mul_y;
    logic [EL_W-1:0]  mul_p;
    logic [EL_W-1:0]  sum_fin;
    logic [CNT_W-1:0] out_idx;
    logic [EL_W-1:0]  ident_val;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EL_W-1:0]  ram_wdata;
    logic             ram_re_a;
    logic [AW-1:0]    ram_raddr_a;
    logic [EL_W-1:0]  ram_q_a;
    logic             ram_re_b;
    logic [AW-1:0]    ram_raddr_b;
    logic [EL_W-1:0]  ram_q_b;

    function automatic logic [CNT_W-1:0] elem_idx(input logic [IW-1:0] hi,
                                                   input logic [IW-1:0] lo);
        elem_idx = CNT_W'(hi) * CNT_W'(m3pow_pkg::MAT_DIM) + CNT_W'(lo);
    endfunction

    function automatic logic [AW-1:0] bank_addr(input logic [BW-1:0]    bank,
                                                input logic [CNT_W-1:0] idx);
        bank_addr = AW'(bank) * AW'(m3pow_pkg::MAT_ELEMS) + AW'(idx);
    endfunction

    // pick the bank that holds neither the accumulator nor the square
    function automatic logic [BW-1:0] free_bank(input logic [BW-1:0] a,
                                                input logic [BW-1:0] s);
        if (a != BW'(0) && s != BW'(0)) begin
            free_bank = BW'(0);
        end else if (a != BW'(1) && s != BW'(1)) begin
            free_bank = BW'(1);
        end else begin
            free_bank = BW'(2);
        end
    endfunction

    m3pow_ram #(
        .WIDTH (EL_W),
        .DEPTH (m3pow_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re_a    (ram_re_a),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_q_a),
        .i_re_b    (ram_re_b),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_q_b)
    );

    // ---- datapath control ----
    always_comb begin
        // during the last multiplier pass, fetch operands for the next k
        rd_k   = (r_state == m3pow_pkg::S_M2) ? r_k + IW'(1) : r_k;
        bank_a = (r_op == m3pow_pkg::OP_MUL) ? r_acc_ptr : r_sq_ptr;

        ram_re_b    = (r_state == m3pow_pkg::S_RD)
                   || (r_state == m3pow_pkg::S_M2 && r_k != LAST_IDX);
        ram_re_a    = ram_re_b || (r_state == m3pow_pkg::S_OUT && r_cnt != OUT_END);
        ram_raddr_a = (r_state == m3pow_pkg::S_OUT) ? bank_addr(r_acc_ptr, r_cnt)
                                                    : bank_addr(bank_a, elem_idx(r_row, rd_k));
        ram_raddr_b = bank_addr(r_sq_ptr, elem_idx(rd_k, r_col));

        case (r_state)
            m3pow_pkg::S_M1: begin
                mul_x = ram_q_a[HW-1:0];
                mul_y = ram_q_b[EL_W-1:HW];
            end
            m3pow_pkg::S_M2: begin
                mul_x = ram_q_a[EL_W-1:HW];
                mul_y = ram_q_b[HW-1:0];
            end
            default: begin
                mul_x = ram_q_a[HW-1:0];
                mul_y = ram_q_b[HW-1:0];
            end
        endcase
        mul_p   = mul_x * mul_y;
        sum_fin = r_sum + {r_prod[HW-1:0], {HW{1'b0}}};

        ram_we    = (r_state == m3pow_pkg::S_LOAD)
                 || (r_state == m3pow_pkg::S_ACC && r_k == LAST_IDX);
        ram_waddr = (r_state == m3pow_pkg::S_LOAD) ? bank_addr(m3pow_pkg::BANK_LOAD, r_cnt)
                                                   : bank_addr(r_dst, elem_idx(r_row, r_col));
        ram_wdata = (r_state == m3pow_pkg::S_LOAD) ? r_in[r_cnt] : sum_fin;

        out_idx   = r_cnt - CNT_W'(1);
        ident_val = (out_idx == CNT_W'(0) || out_idx == CNT_W'(4) || out_idx == CNT_W'(8))
                  ? EL_W'(1) : '0;
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= m3pow_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = (r_state != m3pow_pkg::S_IDLE);
        case (r_state)
            m3pow_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = m3pow_pkg::S_LOAD;
                end
            end
            m3pow_pkg::S_LOAD: begin
                if (r_cnt == LAST_ELEM) begin
                    n_state = m3pow_pkg::S_BIT;
                end
            end
            m3pow_pkg::S_BIT: begin
                if (r_exp == '0) begin
                    n_state = m3pow_pkg::S_OUTW;
                end else if (r_exp[0] && !r_bit_mul) begin
                    if (!r_acc_id) begin
                        n_state = m3pow_pkg::S_RD;
                    end
                end else if ((r_exp >> 1) != '0) begin
                    n_state = m3pow_pkg::S_RD;
                end
            end
            m3pow_pkg::S_RD: n_state = m3pow_pkg::S_M0;
            m3pow_pkg::S_M0: n_state = m3pow_pkg::S_M1;
            m3pow_pkg::S_M1: n_state = m3pow_pkg::S_M2;
            m3pow_pkg::S_M2: n_state = m3pow_pkg::S_ACC;
            m3pow_pkg::S_ACC: begin
                if (r_k != LAST_IDX) begin
                    n_state = m3pow_pkg::S_M0;
                end else if (r_row == LAST_IDX && r_col == LAST_IDX) begin
                    n_state = m3pow_pkg::S_BIT;
                end else begin
                    n_state = m3pow_pkg::S_RD;
                end
            end
            m3pow_pkg::S_OUTW: begin
                if (!r_ovalid) begin
                    n_state = m3pow_pkg::S_OUT;
                end
            end
            m3pow_pkg::S_OUT: begin
                if (r_cnt == OUT_END) begin
                    n_state = m3pow_pkg::S_IDLE;
                end
            end
            default: n_state = m3pow_pkg::S_IDLE;
        endcase
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid  <= 1'b0;
            r_acc_id  <= 1'b1;
            r_bit_mul <= 1'b0;
            r_acc_ptr <= m3pow_pkg::BANK_LOAD;
            r_sq_ptr  <= m3pow_pkg::BANK_LOAD;
            r_dst     <= '0;
            r_op      <= m3pow_pkg::OP_SQR;
            r_exp     <= '0;
            r_cnt     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_k       <= '0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                m3pow_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_in[0]   <= i_req.base_r0c0;
                        r_in[1]   <= i_req.base_r0c1;
                        r_in[2]   <= i_req.base_r0c2;
                        r_in[3]   <= i_req.base_r1c0;
                        r_in[4]   <= i_req.base_r1c1;
                        r_in[5]   <= i_req.base_r1c2;
                        r_in[6]   <= i_req.base_r2c0;
                        r_in[7]   <= i_req.base_r2c1;
                        r_in[8]   <= i_req.base_r2c2;
                        r_exp     <= i_req.power[EW-1:0];
                        r_acc_id  <= 1'b1;
                        r_bit_mul <= 1'b0;
                        r_acc_ptr <= m3pow_pkg::BANK_LOAD;
                        r_sq_ptr  <= m3pow_pkg::BANK_LOAD;
                        r_cnt     <= '0;
                    end
                end
                m3pow_pkg::S_LOAD: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                m3pow_pkg::S_BIT: begin
                    r_row <= '0;
                    r_col <= '0;
                    r_k   <= '0;
                    r_dst <= free_bank(r_acc_ptr, r_sq_ptr);
                    if (r_exp == '0) begin
                        r_cnt <= '0;
                    end else if (r_exp[0] && !r_bit_mul) begin
                        if (r_acc_id) begin
                            // identity times square: just take over the square's bank
                            r_acc_ptr <= r_sq_ptr;
                            r_acc_id  <= 1'b0;
                            r_bit_mul <= 1'b1;
                        end else begin
                            r_op <= m3pow_pkg::OP_MUL;
                        end
                    end else if ((r_exp >> 1) == '0) begin
                        // no set bits left: drop the final squaring
                        r_exp <= '0;
                    end else begin
                        r_op <= m3pow_pkg::OP_SQR;
                    end
                end
                m3pow_pkg::S_M0: begin
                    r_prod <= mul_p;
                end
                m3pow_pkg::S_M1: begin
                    r_prod <= mul_p;
                    r_sum  <= (r_k == '0) ? r_prod : r_sum + r_prod;
                end
                m3pow_pkg::S_M2: begin
                    r_prod <= mul_p;
                    r_sum  <= r_sum + {r_prod[HW-1:0], {HW{1'b0}}};
                end
                m3pow_pkg::S_ACC: begin
                    r_sum <= sum_fin;
                    if (r_k != LAST_IDX) begin
                        r_k <= r_k + IW'(1);
                    end else begin
                        r_k <= '0;
                        if (r_col != LAST_IDX) begin
                            r_col <= r_col + IW'(1);
                        end else begin
                            r_col <= '0;
                            if (r_row != LAST_IDX) begin
                                r_row <= r_row + IW'(1);
                            end else begin
                                r_row <= '0;
                                if (r_op == m3pow_pkg::OP_MUL) begin
                                    r_acc_ptr <= r_dst;
                                    r_bit_mul <= 1'b1;
                                end else begin
                                    r_sq_ptr  <= r_dst;
                                    r_exp     <= r_exp >> 1;
                                    r_bit_mul <= 1'b0;
                                end
                            end
                        end
                    end
                end
                m3pow_pkg::S_OUT: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt != '0) begin
                        r_res[out_idx] <= r_acc_id ? ident_val : ram_q_a;
                    end
                    if (r_cnt == OUT_END) begin
                        r_ovalid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_res.out_r0c0 = r_res[0];
    assign o_res.out_r0c1 = r_res[1];
    assign o_res.out_r0c2 = r_res[2];
    assign o_res.out_r1c0 = r_res[3];
    assign o_res.out_r1c1 = r_res[4];
    assign o_res.out_r1c2 = r_res[5];
    assign o_res.out_r2c0 = r_res[6];
    assign o_res.out_r2c1 = r_res[7];
    assign o_res.out_r2c2 = r_res[8];

    // ---- assertions ----
    a_dst_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == m3pow_pkg::S_ACC) |->
            (r_dst != r_sq_ptr && (r_op == m3pow_pkg::OP_SQR || r_dst != r_acc_ptr)))
        else $error("product destination overlaps an operand bank");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == m3pow_pkg::S_LOAD || r_state == m3pow_pkg::S_ACC))
        else $error("matrix store written outside load or accumulate");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == m3pow_pkg::S_OUT))
        else $error("result raised without readout");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == m3pow_pkg::S_LOAD))
        else $error("accepted request did not start loading");

endmodule
`default_nettype wire

// ----- verif/matrix3_power_by_squaring_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3_power_by_squaring_unit_tb
// Self-checking bench for the 3x3 matrix power unit. Requests carry a base
// matrix and an exponent; a scoreboard computes each power by repeated
// squaring with 64-bit wrapping and checks every result element in order.
// The sender works in bursts with random gaps and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module matrix3_power_by_squaring_unit_tb;

    localparam int SCAN_BITS  = m3pow_pkg::EXP_BITS_DEF;
    localparam int NUM_RANDOM = 1750;
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN_WAIT = 64;

    typedef logic [m3pow_pkg::MAT_ELEMS-1:0][m3pow_pkg::ELEM_W-1:0] t_mat;

    typedef enum logic [1:0] {
        RX_READY,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } t_rx_mode;

    function automatic t_mat mat_of_req(m3pow_pkg::t_req r);
        t_mat m;
        for (int k = 0; k < m3pow_pkg::MAT_ELEMS; k++)
            m[k] = r[m3pow_pkg::POW_W + (m3pow_pkg::MAT_ELEMS - 1 - k) * m3pow_pkg::ELEM_W
                     +: m3pow_pkg::ELEM_W];
        return m;
    endfunction

    function automatic t_mat mat_of_rsp(m3pow_pkg::t_rsp r);
        t_mat m;
        for (int k = 0; k < m3pow_pkg::MAT_ELEMS; k++)
            m[k] = r[(m3pow_pkg::MAT_ELEMS - 1 - k) * m3pow_pkg::ELEM_W +: m3pow_pkg::ELEM_W];
        return m;
    endfunction

    class power_scoreboard;
        t_mat        expected_powers[$];
        int unsigned n_requests;
        int unsigned n_results;
        int unsigned n_mismatch;

        function t_mat mat_product(t_mat a, t_mat b);
            t_mat                        t;
            logic [m3pow_pkg::ELEM_W-1:0] s;
            for (int r = 0; r < m3pow_pkg::MAT_DIM; r++) begin
                for (int c = 0; c < m3pow_pkg::MAT_DIM; c++) begin
                    s = '0;
                    for (int k = 0; k < m3pow_pkg::MAT_DIM; k++)
                        s += a[r * m3pow_pkg::MAT_DIM + k] * b[k * m3pow_pkg::MAT_DIM + c];
                    t[r * m3pow_pkg::MAT_DIM + c] = s;
                end
            end
            return t;
        endfunction

        function t_mat matrix_power(t_mat base, logic [m3pow_pkg::POW_W-1:0] p);
            t_mat acc;
            t_mat sq;
            acc = '0;
            acc[0] = m3pow_pkg::ELEM_W'(1);
            acc[4] = m3pow_pkg::ELEM_W'(1);
            acc[8] = m3pow_pkg::ELEM_W'(1);
            sq = base;
            // exponent bits above the power field read as zero
            for (int i = 0; i < SCAN_BITS; i++) begin
                if (i < m3pow_pkg::POW_W && p[i])
                    acc = mat_product(acc, sq);
                sq = mat_product(sq, sq);
            end
            return acc;
        endfunction

        function void note_request(m3pow_pkg::t_req r);
            expected_powers.insert(expected_powers.size(),
                                   matrix_power(mat_of_req(r), r.power));
            n_requests++;
        endfunction

        function void check_result(m3pow_pkg::t_rsp r);
            t_mat want;
            t_mat got;
            got = mat_of_rsp(r);
            if (expected_powers.size() == 0) begin
                $display("%0t: result with no request outstanding: actual %h", $time, r);
                n_mismatch++;
                return;
            end
            want = expected_powers.pop_front();
            for (int k = 0; k < m3pow_pkg::MAT_ELEMS; k++) begin
                if (got[k] !== want[k]) begin
                    $display("%0t: result %0d out_r%0dc%0d: expected %h actual %h",
                             $time, n_results, k / m3pow_pkg::MAT_DIM,
                             k % m3pow_pkg::MAT_DIM, want[k], got[k]);
                    n_mismatch++;
                end
            end
            n_results++;
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    m3pow_pkg::t_req i_req;
    logic            o_valid;
    logic            i_stall = 1'b0;
    m3pow_pkg::t_rsp o_res;

    power_scoreboard sb;
    int unsigned     idle_cycles = 0;
    logic [15:0]     rx_phase = '0;
    t_rx_mode        rx_mode = RX_READY;

    matrix3_power_by_squaring_unit #(
        .EXP_BITS(SCAN_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: switch stall pattern whenever the low byte of rx_phase wraps to zero
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase[7:0] == 8'd0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_READY:    i_stall <= 1'b0;
            RX_RANDOM:   i_stall <= ($urandom_range(0, 2) == 0);
            RX_PERIODIC: i_stall <= (rx_phase[3:0] < 4'd6);
            default:     i_stall <= (rx_phase[5:0] < 6'd40);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_request(i_req);
            if (o_valid && !i_stall)
                sb.check_result(o_res);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, sb.expected_powers.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold the request until it is taken
    task automatic push_request(input t_mat m, input logic [m3pow_pkg::POW_W-1:0] p);
        m3pow_pkg::t_req r;
        for (int k = 0; k < m3pow_pkg::MAT_ELEMS; k++)
            r[m3pow_pkg::POW_W + (m3pow_pkg::MAT_ELEMS - 1 - k) * m3pow_pkg::ELEM_W
              +: m3pow_pkg::ELEM_W] = m[k];
        r.power = p;
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic t_mat rows(longint a0, longint a1, longint a2,
                                  longint a3, longint a4, longint a5,
                                  longint a6, longint a7, longint a8);
        t_mat m;
        m[0] = a0; m[1] = a1; m[2] = a2;
        m[3] = a3; m[4] = a4; m[5] = a5;
        m[6] = a6; m[7] = a7; m[8] = a8;
        return m;
    endfunction

    function automatic t_mat filled(longint v);
        return rows(v, v, v, v, v, v, v, v, v);
    endfunction

    function automatic logic [m3pow_pkg::ELEM_W-1:0] random_elem();
        longint s;
        case ($urandom_range(0, 9))
            7:       return 64'h7fff_ffff_ffff_ffff;
            8:       return 64'h8000_0000_0000_0000;
            9:       return '1;
            4, 5, 6: begin
                s = longint'($urandom_range(0, 6)) - 3;
                return s;
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_mat random_matrix();
        t_mat m;
        for (int k = 0; k < m3pow_pkg::MAT_ELEMS; k++)
            m[k] = random_elem();
        return m;
    endfunction

    function automatic t_mat small_matrix();
        t_mat m;
        longint s;
        for (int k = 0; k < m3pow_pkg::MAT_ELEMS; k++) begin
            s = longint'($urandom_range(0, 4)) - 2;
            m[k] = s;
        end
        return m;
    endfunction

    // keep most exponents short to bound the length of the run
    function automatic logic [m3pow_pkg::POW_W-1:0] random_power();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            return $urandom_range(0, 7);
        else if (pick < 98)
            return $urandom_range(8, 31);
        return $urandom;
    endfunction

    localparam longint MAXV = 64'sh7fff_ffff_ffff_ffff;
    localparam longint MINV = 64'sh8000_0000_0000_0000;

    initial begin
        int unsigned burst_left;
        int unsigned gap;

        sb      = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_request(rows(1, 0, 0, 0, 1, 0, 0, 0, 1), 32'hffff_ffff);
        push_request(filled(0), 32'd0);
        push_request(filled(0), 32'd1);
        push_request(filled(MAXV), 32'd2);
        push_request(filled(MINV), 32'd3);
        push_request(filled(-1), 32'h8000_0000);
        push_request(rows(1, 1, 0, 1, 0, 0, 0, 0, 1), 32'd200);
        push_request(random_matrix(), 32'hffff_ffff);
        push_request(random_matrix(), 32'd1);
        push_request(random_matrix(), 32'h7fff_ffff);
        push_request(rows(0, 1, 0, 0, 0, 1, 1, 0, 0), 32'hffff_fffe);
        push_request(rows(2, 0, 0, 0, 3, 0, 0, 0, -1), 32'd63);
        push_request(rows(-1, 0, 0, 0, MAXV, 0, 0, 0, MINV), 32'd5);
        push_request(rows(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV), 32'd4);
        // nilpotent: third power vanishes
        push_request(rows(0, 1, 1, 0, 0, 1, 0, 0, 0), 32'd3);
        push_request(small_matrix(), 32'h5555_5555);
        push_request(random_matrix(), 32'haaaa_aaaa);
        push_request(filled(0), 32'hffff_ffff);

        burst_left = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                  : $urandom_range(0, 4);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 8);
            end
            if ($urandom_range(0, 3) == 0)
                push_request(small_matrix(), random_power());
            else
                push_request(random_matrix(), random_power());
            burst_left--;
        end
        i_valid <= 1'b0;

        while (sb.expected_powers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d requests and %0d results, %0d element mismatches.",
                 sb.n_requests, sb.n_results, sb.n_mismatch);
        $display("Exponents from zero to all ones, extreme and random bases, stalls on both sides.");
        if (sb.n_mismatch == 0 && sb.expected_powers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/m3pow_pkg.sv
sv/m3pow_ram.sv
sv/matrix3_power_by_squaring_unit.sv
verif/matrix3_power_by_squaring_unit_tb.sv
